>>> rtl/lcdws_pkg.sv
`timescale 1ns / 1ps
// lcdws_pkg: types, constants and the init command table of the 4-bit lcd write sequencer
// no dependencies; imported by every module of the block

package lcdws_pkg;

	localparam int LCDWS_QUEUE_DEPTH = 2;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int HOLD_W = 17;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WAIT = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_WAIT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WAIT = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_POWER_ON_WAIT = 8'd3;

	localparam logic [7:0] PULSE_WAIT_RST = 8'd1;
	localparam logic [9:0] SETTLE_WAIT_RST = 10'd45;
	localparam logic [15:0] CLEAR_WAIT_RST = 16'd2000;
	localparam logic [15:0] POWER_ON_WAIT_RST = 16'd20000;

	localparam logic [HOLD_W-1:0] WAKE_WAIT_LONG_US = 17'd5000;
	localparam logic [HOLD_W-1:0] WAKE_WAIT_SHORT_US = 17'd200;

	// instruction codes below this limit need the clear/home wait
	localparam logic [7:0] CLEAR_CODE_LIMIT = 8'd4;
	localparam logic [3:0] WAKE_NIBBLE = 4'h3;

	// init byte slots: slot 0 is the lone nibble 2, slots 1..5 the commands
	localparam logic [2:0] INIT_SLOT_NIBBLE2 = 3'd0;
	localparam logic [2:0] INIT_SLOT_LAST = 3'd5;

	// steps inside one byte: 0..2 high nibble, 3..5 low nibble
	localparam logic [2:0] SUB_FIRST_LOW = 3'd3;
	localparam logic [2:0] SUB_LAST = 3'd5;
	localparam logic [2:0] WAKE_LAST = 3'd7;

	localparam logic [2:0] WAKE_LONG_STEP = 3'd3;
	localparam logic [2:0] WAKE_SHORT_STEP = 3'd5;
	localparam logic [2:0] WAKE_SETTLE_STEP = 3'd7;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
		logic       is_data;
	} lcd_cmd_t;

	typedef struct packed {
		logic [3:0]        data_nibble;
		logic              reg_select;
		logic              enable_level;
		logic [HOLD_W-1:0] hold_us;
		logic              last;
	} lcd_res_t;

	// classified request as kept in the queue
	typedef struct packed {
		logic       is_init;
		logic [7:0] code;
		logic       rs;
		logic       tail;
	} seq_job_t;

	typedef struct packed {
		logic [7:0]  pulse;
		logic [9:0]  settle;
		logic [15:0] clear;
		logic [15:0] power_on;
	} timing_cfg_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_WAKE,
		PH_BYTE
	} seq_phase_t;

	function automatic logic [7:0] init_command(input logic [2:0] slot);
		logic [7:0] code;
		unique case (slot)
			3'd1:    code = 8'h28;
			3'd2:    code = 8'h08;
			3'd3:    code = 8'h01;
			3'd4:    code = 8'h0F;
			3'd5:    code = 8'h80;
			default: code = 8'h02;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/lcdws_front.sv
`timescale 1ns / 1ps
// lcdws_front: accepts requests, classifies them and keeps them in a short queue
// depends on lcdws_pkg

module lcdws_front #(
	parameter int Depth = lcdws_pkg::LCDWS_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lcdws_pkg::lcd_cmd_t   cmd,
	output logic                  full,
	output logic                  job_valid,
	output lcdws_pkg::seq_job_t   job,
	input  logic                  job_pop
);
	import lcdws_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	seq_job_t            store_q [Depth];
	seq_job_t            entry;
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                wr_en;

	// only an instruction write can need the clear/home tail
	always_comb begin
		entry.is_init = cmd.func;
		entry.code    = cmd.byte_value;
		entry.rs      = cmd.is_data & ~cmd.func;
		entry.tail    = ~cmd.func & ~cmd.is_data & (cmd.byte_value < CLEAR_CODE_LIMIT);
	end

	assign full      = (count_q == CntW'(Depth));
	assign wr_en     = push && !full;
	assign job_valid = (count_q != '0);
	assign job       = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (job_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, job_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/lcdws_back.sv
`timescale 1ns / 1ps
// lcdws_back: steps through the pin states of the queued request, one per cycle unless
// the receiver stalls, into the result register; depends on lcdws_pkg

module lcdws_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdws_pkg::timing_cfg_t tcfg,
	input  logic                   job_valid,
	input  lcdws_pkg::seq_job_t    job,
	output logic                   job_pop,
	output logic                   empty,
	input  logic                   pop,
	output lcdws_pkg::lcd_res_t    res
);
	import lcdws_pkg::*;

	seq_phase_t        phase_q, phase_d;
	logic [2:0]        wake_q, wake_d;
	logic [2:0]        sub_q, sub_d;
	logic [2:0]        slot_q, slot_d;
	logic [3:0]        pin_nibble_q;
	logic              res_valid_q;
	lcd_res_t          res_q;

	logic [7:0]        src_code;
	logic              src_rs;
	logic              src_tail;
	logic [HOLD_W-1:0] pulse_h, settle_h;
	lcd_res_t          byte_res, gen_res;
	logic              fire;

	assign pulse_h  = {{(HOLD_W-8){1'b0}}, tcfg.pulse};
	assign settle_h = {{(HOLD_W-10){1'b0}}, tcfg.settle};
	assign fire     = job_valid && (!res_valid_q || pop);

	// byte source: the request itself or the init table
	always_comb begin
		if (job.is_init) begin
			src_code = init_command(slot_q);
			src_rs   = 1'b0;
			src_tail = (slot_q != INIT_SLOT_NIBBLE2) && (src_code < CLEAR_CODE_LIMIT);
		end else begin
			src_code = job.code;
			src_rs   = job.rs;
			src_tail = job.tail;
		end
	end

	always_comb begin
		byte_res.data_nibble  = (sub_q < SUB_FIRST_LOW) ? src_code[7:4] : src_code[3:0];
		byte_res.reg_select   = src_rs;
		byte_res.enable_level = (sub_q == 3'd1) || (sub_q == 3'd4);
		case (sub_q)
			3'd2:    byte_res.hold_us = settle_h;
			3'd5:    byte_res.hold_us = settle_h +
				(src_tail ? {1'b0, tcfg.clear} : {HOLD_W{1'b0}});
			default: byte_res.hold_us = pulse_h;
		endcase
		byte_res.last = (sub_q == SUB_LAST) && (!job.is_init || slot_q == INIT_SLOT_LAST);
	end

	// output decode
	always_comb begin
		gen_res = byte_res;
		unique case (phase_q)
			PH_START: begin
				if (job.is_init) begin
					gen_res.data_nibble  = pin_nibble_q;
					gen_res.reg_select   = 1'b0;
					gen_res.enable_level = 1'b0;
					gen_res.hold_us      = {1'b0, tcfg.power_on};
					gen_res.last         = 1'b0;
				end
			end
			PH_WAKE: begin
				gen_res.data_nibble  = WAKE_NIBBLE;
				gen_res.reg_select   = 1'b0;
				gen_res.enable_level = ~wake_q[0];
				gen_res.last         = 1'b0;
				case (wake_q)
					WAKE_LONG_STEP:   gen_res.hold_us = settle_h + WAKE_WAIT_LONG_US + pulse_h;
					WAKE_SHORT_STEP:  gen_res.hold_us = settle_h + WAKE_WAIT_SHORT_US + pulse_h;
					WAKE_SETTLE_STEP: gen_res.hold_us = settle_h;
					default:          gen_res.hold_us = pulse_h;
				endcase
			end
			PH_BYTE: begin
				gen_res = byte_res;
			end
			default: begin
				gen_res = byte_res;
			end
		endcase
		job_pop = fire && gen_res.last;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		wake_d  = wake_q;
		sub_d   = sub_q;
		slot_d  = slot_q;
		if (fire) begin
			unique case (phase_q)
				PH_START: begin
					if (job.is_init) begin
						phase_d = PH_WAKE;
						wake_d  = 3'd1;
					end else begin
						phase_d = PH_BYTE;
						sub_d   = 3'd1;
					end
				end
				PH_WAKE: begin
					if (wake_q == WAKE_LAST) begin
						phase_d = PH_BYTE;
						slot_d  = INIT_SLOT_NIBBLE2;
						sub_d   = SUB_FIRST_LOW;
					end else begin
						wake_d = wake_q + 1'b1;
					end
				end
				PH_BYTE: begin
					if (sub_q != SUB_LAST) begin
						sub_d = sub_q + 1'b1;
					end else if (job.is_init && slot_q != INIT_SLOT_LAST) begin
						slot_d = slot_q + 1'b1;
						sub_d  = 3'd0;
					end else begin
						phase_d = PH_START;
						sub_d   = 3'd0;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			wake_q       <= '0;
			sub_q        <= '0;
			slot_q       <= '0;
			pin_nibble_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			wake_q  <= wake_d;
			sub_q   <= sub_d;
			slot_q  <= slot_d;
			if (fire) begin
				pin_nibble_q <= gen_res.data_nibble;
				res_valid_q  <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= gen_res;
		end
	end

	assign empty = !res_valid_q;
	assign res   = res_q;

	a_wake_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAKE |-> wake_q != 3'd0)
		else $error("wake step counter at zero inside wake phase");

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BYTE |-> sub_q <= SUB_LAST)
		else $error("byte step past last step");

	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> phase_q == PH_START && sub_q == 3'd0)
		else $error("sequencer not back at start after finishing a request");

	a_init_enters_wake: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_START && job.is_init |=> phase_q == PH_WAKE && wake_q == 3'd1)
		else $error("initialize did not enter the wake-up nibbles");

	a_pulse_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.enable_level |-> !res_q.last)
		else $error("request ended with enable high");

endmodule

>>> rtl/lcd_4bit_write_sequencer_unit.sv
`timescale 1ns / 1ps
// lcd_4bit_write_sequencer_unit: top level, configuration registers and the two halves
// depends on lcdws_pkg, lcdws_front, lcdws_back
//
// usage
// - request channel: cmd is taken at a clock edge with push high and full low.
//   func 0 writes byte_value as an instruction (is_data 0) or a character (is_data 1);
//   func 1 runs the power-on initialize sequence and ignores the other fields
// - result channel: while empty is low, res holds the oldest pin state (data nibble,
//   rs, e, hold time in us, last flag); it is taken at an edge with pop high
// - configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
//   (0 pulse wait, 1 settle wait, 2 clear wait, 3 power-on wait); other indexes are
//   ignored; write only while no request is in flight
// - path: with the sequencer idle, a taken request is written into the queue and its
//   first pin state is then registered into the result register
// - throughput: the back sequencer emits one pin state per cycle unless the receiver
//   stalls; a byte write is 6 pin states, initialize 41; requests follow with no gap
// - a two-entry request queue sits between the classifier and the sequencer, so new
//   requests are taken while the sequencer is busy or the receiver stalls
// - receiver stall: the result register holds, the sequencer waits, and full rises
//   once the queue is filled
// - reset: queue and result register empty, last data nibble zero, timing registers at
//   1, 45, 2000 and 20000 us

module lcd_4bit_write_sequencer_unit #(
	parameter int QueueDepth = lcdws_pkg::LCDWS_QUEUE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  lcdws_pkg::lcd_cmd_t                    cmd,
	output logic                                   full,
	output logic                                   empty,
	input  logic                                   pop,
	output lcdws_pkg::lcd_res_t                    res,
	input  logic                                   cfg_we,
	input  logic [lcdws_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lcdws_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lcdws_pkg::*;

	timing_cfg_t tcfg_q;
	logic        job_valid;
	seq_job_t    job;
	logic        job_pop;

	// timing registers, each keeps the low bits of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.pulse    <= PULSE_WAIT_RST;
			tcfg_q.settle   <= SETTLE_WAIT_RST;
			tcfg_q.clear    <= CLEAR_WAIT_RST;
			tcfg_q.power_on <= POWER_ON_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PULSE_WAIT:    tcfg_q.pulse    <= cfg_data[7:0];
				REG_SETTLE_WAIT:   tcfg_q.settle   <= cfg_data[9:0];
				REG_CLEAR_WAIT:    tcfg_q.clear    <= cfg_data;
				REG_POWER_ON_WAIT: tcfg_q.power_on <= cfg_data;
				default:           tcfg_q          <= tcfg_q;
			endcase
		end
	end

	// front: classify and queue requests
	lcdws_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.full      (full),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// back: walk the pin states of the head request
	lcdws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tcfg      (tcfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

>>> dv/lcdws_pin_checker.sv
`timescale 1ns / 1ps
// lcdws_pin_checker: works out the lcd pin states each taken request should give and checks them
// against the result channel; depends on lcdws_pkg, instantiated beside the sequencer by testbench

module lcdws_pin_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  lcdws_pkg::lcd_cmd_t                 cmd,
	input  logic                                full,
	input  logic                                empty,
	input  logic                                pop,
	input  lcdws_pkg::lcd_res_t                 res,
	input  logic                                cfg_we,
	input  logic [lcdws_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lcdws_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                  errors,
	output int                                  outstanding,
	output int                                  requests_taken,
	output int                                  inits_taken,
	output int                                  pins_checked
);
	import lcdws_pkg::*;

	localparam int MAX_PRINTED = 40;
	localparam logic [HOLD_W-1:0] POWER_UP_LONG_US = 17'd5000;
	localparam logic [HOLD_W-1:0] POWER_UP_SHORT_US = 17'd200;
	localparam logic [3:0] WAKE_CODE = 4'h3;
	localparam logic [3:0] FOUR_BIT_CODE = 4'h2;
	localparam logic [7:0] SLOW_CODE_LIMIT = 8'd4;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
	localparam logic [7:0] CMD_HOME_ADDR = 8'h80;

	logic [7:0]  pulse_us;
	logic [9:0]  settle_us;
	logic [15:0] clear_us;
	logic [15:0] power_on_us;
	logic [3:0]  bus_nibble;
	lcd_res_t    pins_due[$];

	initial begin
		errors = 0;
		outstanding = 0;
		requests_taken = 0;
		inits_taken = 0;
		pins_checked = 0;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	task automatic add_pins(input logic [3:0] nib, input logic rs, input logic en,
			input logic [HOLD_W-1:0] hold);
		lcd_res_t p;
		p.data_nibble = nib;
		p.reg_select = rs;
		p.enable_level = en;
		p.hold_us = hold;
		p.last = 1'b0;
		pins_due.push_back(p);
		bus_nibble = nib;
	endtask

	// set pins with e low, e high, e low and settle
	task automatic strobe_nibble(input logic [3:0] nib, input logic rs,
			input logic [HOLD_W-1:0] extra);
		logic [HOLD_W-1:0] settle_hold;
		settle_hold = HOLD_W'(settle_us);
		settle_hold = settle_hold + extra;
		add_pins(nib, rs, 1'b0, HOLD_W'(pulse_us));
		add_pins(nib, rs, 1'b1, HOLD_W'(pulse_us));
		add_pins(nib, rs, 1'b0, settle_hold);
	endtask

	task automatic send_code(input logic [7:0] code, input logic rs);
		logic [HOLD_W-1:0] tail;
		tail = (!rs && code < SLOW_CODE_LIMIT) ? HOLD_W'(clear_us) : '0;
		strobe_nibble(code[7:4], rs, '0);
		strobe_nibble(code[3:0], rs, tail);
	endtask

	task automatic predict_request(input lcd_cmd_t c);
		logic [HOLD_W-1:0] long_hold;
		logic [HOLD_W-1:0] short_hold;
		lcd_res_t tail_pins;
		long_hold = HOLD_W'(settle_us);
		long_hold = long_hold + POWER_UP_LONG_US + HOLD_W'(pulse_us);
		short_hold = HOLD_W'(settle_us);
		short_hold = short_hold + POWER_UP_SHORT_US + HOLD_W'(pulse_us);
		if (!c.func) begin
			send_code(c.byte_value, c.is_data);
		end else begin
			// byte_value and is_data play no part here
			add_pins(bus_nibble, 1'b0, 1'b0, HOLD_W'(power_on_us));
			add_pins(WAKE_CODE, 1'b0, 1'b0, HOLD_W'(pulse_us));
			add_pins(WAKE_CODE, 1'b0, 1'b1, HOLD_W'(pulse_us));
			add_pins(WAKE_CODE, 1'b0, 1'b0, long_hold);
			add_pins(WAKE_CODE, 1'b0, 1'b1, HOLD_W'(pulse_us));
			add_pins(WAKE_CODE, 1'b0, 1'b0, short_hold);
			add_pins(WAKE_CODE, 1'b0, 1'b1, HOLD_W'(pulse_us));
			add_pins(WAKE_CODE, 1'b0, 1'b0, HOLD_W'(settle_us));
			strobe_nibble(FOUR_BIT_CODE, 1'b0, '0);
			send_code(CMD_FUNCTION_SET, 1'b0);
			send_code(CMD_DISPLAY_OFF, 1'b0);
			send_code(CMD_CLEAR, 1'b0);
			send_code(CMD_DISPLAY_ON, 1'b0);
			send_code(CMD_HOME_ADDR, 1'b0);
		end
		tail_pins = pins_due.pop_back();
		tail_pins.last = 1'b1;
		pins_due.push_back(tail_pins);
	endtask

	task automatic check_pins(input lcd_res_t got);
		lcd_res_t want;
		if (pins_due.size() == 0) begin
			report($sformatf("pin state nibble %0d hold %0d with none due",
				got.data_nibble, got.hold_us));
		end else begin
			want = pins_due.pop_front();
			if (got.data_nibble !== want.data_nibble)
				report($sformatf("pin state %0d data_nibble: got %0d, want %0d",
					pins_checked, got.data_nibble, want.data_nibble));
			if (got.reg_select !== want.reg_select)
				report($sformatf("pin state %0d reg_select: got %0d, want %0d",
					pins_checked, got.reg_select, want.reg_select));
			if (got.enable_level !== want.enable_level)
				report($sformatf("pin state %0d enable_level: got %0d, want %0d",
					pins_checked, got.enable_level, want.enable_level));
			if (got.hold_us !== want.hold_us)
				report($sformatf("pin state %0d hold_us: got %0d, want %0d",
					pins_checked, got.hold_us, want.hold_us));
			if (got.last !== want.last)
				report($sformatf("pin state %0d last: got %0d, want %0d",
					pins_checked, got.last, want.last));
		end
		pins_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_us = 8'd1;
			settle_us = 10'd45;
			clear_us = 16'd2000;
			power_on_us = 16'd20000;
			bus_nibble = '0;
			pins_due.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PULSE_WAIT:    pulse_us = cfg_data[7:0];
					REG_SETTLE_WAIT:   settle_us = cfg_data[9:0];
					REG_CLEAR_WAIT:    clear_us = cfg_data;
					REG_POWER_ON_WAIT: power_on_us = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				check_pins(res);
			end
			if (push && !full) begin
				predict_request(cmd);
				requests_taken++;
				if (cmd.func) begin
					inits_taken++;
				end
			end
			outstanding = pins_due.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives requests, timing writes and result pops into the 4-bit lcd write sequencer
// depends on lcdws_pkg, lcd_4bit_write_sequencer_unit and lcdws_pin_checker

module testbench;
	import lcdws_pkg::*;

	// a full initialize is 41 pin states, each can wait out a pop stall of up to idle_max
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_SETTING = 30;
	localparam int END_SETTLE_CYCLES = 20;

	// indexes past the register list, the block has to ignore them
	localparam logic [CFG_INDEX_W-1:0] REG_PAST_LIST = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX = 8'hFF;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_INIT = 1'b1;
	localparam logic RS_INSTR = 1'b0;
	localparam logic RS_CHAR = 1'b1;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	lcd_cmd_t               cmd;
	logic                   full;
	logic                   empty;
	logic                   pop;
	lcd_res_t               res;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int errors;
	int outstanding;
	int requests_taken;
	int inits_taken;
	int pins_checked;
	int cycle_count;
	int settings_run;

	// upper bound of the random wait drawn per request and per pop, 0 gives back to back
	int idle_max;

	lcd_4bit_write_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcdws_pin_checker pin_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.cmd            (cmd),
		.full           (full),
		.empty          (empty),
		.pop            (pop),
		.res            (res),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.outstanding    (outstanding),
		.requests_taken (requests_taken),
		.inits_taken    (inits_taken),
		.pins_checked   (pins_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog, only reached when the run hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[lcd_4bit_write_sequencer_unit] ERROR");
		$finish;
	end

	// result side: random stall before each pop, then hold pop until a pin state is taken
	initial begin
		int stall;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(idle_max, 0);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// one request, with a random gap in front; push stays high when the gap is zero
	task automatic send_request(input logic func, input logic [7:0] code, input logic rs);
		int gap;
		lcd_cmd_t c;
		gap = $urandom_range(idle_max, 0);
		c.func = func;
		c.byte_value = code;
		c.is_data = rs;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// hold requests back until every predicted pin state has been popped
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// cfg_we stays high across a batch, the caller drops it once
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// new timing while idle; values wider than a register check the truncation
	task automatic apply_timing(input logic [15:0] pulse, input logic [15:0] settle,
			input logic [15:0] clear, input logic [15:0] power_on, input bit stray);
		drain();
		write_reg(REG_PULSE_WAIT, pulse);
		write_reg(REG_SETTLE_WAIT, settle);
		write_reg(REG_CLEAR_WAIT, clear);
		write_reg(REG_POWER_ON_WAIT, power_on);
		if (stray) begin
			write_reg(REG_PAST_LIST, 16'hFFFF);
			write_reg(REG_TOP_INDEX, 16'h0000);
		end
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// mostly byte writes, a tenth initialize, instructions leaning toward the slow codes
	task automatic run_random(input int count);
		int pick;
		logic rs;
		logic [7:0] code;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99, 0);
			rs = 1'($urandom_range(1, 0));
			code = (pick < 30) ? 8'($urandom_range(4, 0)) : 8'($urandom_range(255, 0));
			send_request((pick < 10) ? FUNC_INIT : FUNC_WRITE, code, rs);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_max = 5;
		settings_run = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset timing
		// initialize straight out of reset, pins still zero
		send_request(FUNC_INIT, 8'h00, RS_INSTR);
		// clear/home class codes, the boundary above them and the top code
		send_request(FUNC_WRITE, 8'h00, RS_INSTR);
		send_request(FUNC_WRITE, 8'h01, RS_INSTR);
		send_request(FUNC_WRITE, 8'h02, RS_INSTR);
		send_request(FUNC_WRITE, 8'h03, RS_INSTR);
		send_request(FUNC_WRITE, 8'h04, RS_INSTR);
		send_request(FUNC_WRITE, 8'hFF, RS_INSTR);
		// characters with low codes get no clear wait
		send_request(FUNC_WRITE, 8'h00, RS_CHAR);
		send_request(FUNC_WRITE, 8'h03, RS_CHAR);
		send_request(FUNC_WRITE, 8'hFF, RS_CHAR);
		send_request(FUNC_WRITE, 8'hA5, RS_CHAR);
		send_request(FUNC_WRITE, 8'h5A, RS_INSTR);
		// initialize keeps whatever nibble the last byte left and ignores its other fields
		send_request(FUNC_INIT, 8'hFF, RS_CHAR);
		send_request(FUNC_INIT, 8'h5A, RS_INSTR);
		send_request(FUNC_WRITE, 8'h28, RS_INSTR);
		send_request(FUNC_WRITE, 8'h80, RS_INSTR);

		// register extremes, then out of range and stray writes, then random settings
		apply_timing(16'd255, 16'd1023, 16'hFFFF, 16'hFFFF, 1'b1);
		run_random(RANDOM_PER_SETTING);

		idle_max = 0;
		apply_timing(16'd1, 16'd1, 16'd0, 16'd0, 1'b0);
		run_random(RANDOM_PER_SETTING);

		idle_max = 5;
		apply_timing(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		run_random(RANDOM_PER_SETTING);

		// bits above the pulse and settle register widths must be dropped
		apply_timing(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 1'b1);
		run_random(RANDOM_PER_SETTING);

		idle_max = 2;
		apply_timing(16'($urandom_range(255, 1)), 16'($urandom_range(1023, 1)),
			16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)), 1'b0);
		run_random(RANDOM_PER_SETTING);

		idle_max = 5;
		apply_timing(16'($urandom_range(255, 1)), 16'($urandom_range(1023, 1)),
			16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)), 1'b0);
		run_random(RANDOM_PER_SETTING);

		drain();
		repeat (END_SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d initialize) and %0d pin states",
			requests_taken, inits_taken, pins_checked);
		$display("under %0d timing settings, register extremes and stray indexes included",
			settings_run);
		if (errors == 0) begin
			$display("[lcd_4bit_write_sequencer_unit] OK");
		end else begin
			$display("[lcd_4bit_write_sequencer_unit] ERROR");
		end
		$finish;
	end

endmodule
